FILE: sv/rsb_pkg.sv
// Shared constants, types and helpers of the region sharpness and brightness block.
package rsb_pkg;

  localparam int MAX_DIM    = 16384;
  localparam int GRID_SHIFT = 6;
  localparam int LINE_DEPTH = 128;
  localparam int DIM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int SCORE_W    = 17;
  localparam int DIV_N_W    = 40;
  localparam int DIV_D_W    = 24;
  localparam int DIV_CNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EN_SHARP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EN_BRIGHT    = 3'd4;

  localparam logic OP_REGION = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

  typedef struct packed {
    logic        ok;
    logic        do_shp;
    logic        do_brt;
    logic [23:0] grad_sum;
    logic [15:0] grad_cnt;
    logic [22:0] luma_sum;
    logic [14:0] luma_cnt;
  } rsb_job_t;

  function automatic logic [15:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [15:0] r;
    if (v == '0) begin
      r = 16'd1;
    end else if (32'(v) > MAX_DIM) begin
      r = 16'(MAX_DIM);
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: sv/rsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rsb_front.sv
// Front end: configuration, region clipping, raster scan, sampling and accumulation.
module rsb_front #(
  parameter int LINE_DEPTH = rsb_pkg::LINE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic signed [15:0]             in_rect_x,
  input  logic signed [15:0]             in_rect_y,
  input  logic signed [15:0]             in_rect_w,
  input  logic signed [15:0]             in_rect_h,
  input  logic [7:0]                     in_chan0,
  input  logic [7:0]                     in_chan1,
  input  logic [7:0]                     in_chan2,
  input  logic                           in_last_pixel,
  input  logic                           q_full,
  output logic                           job_push,
  output rsb_pkg::rsb_job_t              job
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [14:0] img_w_r, img_h_r;
  logic        color_r, en_shp_r, en_brt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= 15'd640;
      img_h_r  <= 15'd480;
      color_r  <= 1'b1;
      en_shp_r <= 1'b1;
      en_brt_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        rsb_pkg::REG_IMAGE_WIDTH:  img_w_r  <= cfg_data;
        rsb_pkg::REG_IMAGE_HEIGHT: img_h_r  <= cfg_data;
        rsb_pkg::REG_COLOR_MODE:   color_r  <= cfg_data[0];
        rsb_pkg::REG_EN_SHARP:     en_shp_r <= cfg_data[0];
        rsb_pkg::REG_EN_BRIGHT:    en_brt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // An accepted request is registered and held while the line store read completes.
  logic busy_r;
  logic accept;
  logic op_r, last_r;
  logic signed [15:0] rx_r, ry_r, rw_r, rh_r;
  logic [7:0] c0_r, c1_r, c2_r;

  assign in_full = busy_r | q_full;
  assign accept  = in_push & ~in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      last_r <= in_last_pixel;
      rx_r   <= in_rect_x;
      ry_r   <= in_rect_y;
      rw_r   <= in_rect_w;
      rh_r   <= in_rect_h;
      c0_r   <= in_chan0;
      c1_r   <= in_chan1;
      c2_r   <= in_chan2;
    end
  end

  logic [14:0] left_r, top_r, right_r, bottom_r;
  logic [8:0]  step_col_r, step_row_r;
  logic [14:0] pcol_r, prow_r, nsc_r, nsr_r;
  logic [6:0]  sidx_r;
  logic        first_r;
  logic [7:0]  lluma_r;
  logic [22:0] luma_tot_r;
  logic [23:0] grad_tot_r;
  logic [14:0] samp_tot_r;
  logic [15:0] pairs_r;

  logic [14:0] left_nxt, top_nxt, right_nxt, bottom_nxt;
  logic [8:0]  step_col_nxt, step_row_nxt;
  logic [14:0] pcol_nxt, prow_nxt, nsc_nxt, nsr_nxt;
  logic [6:0]  sidx_nxt;
  logic        first_nxt;
  logic [7:0]  lluma_nxt;
  logic [22:0] luma_tot_nxt;
  logic [23:0] grad_tot_nxt;
  logic [14:0] samp_tot_nxt;
  logic [15:0] pairs_nxt;

  // Line store of the previous sampled row.
  logic [31:0]   sidx_ext;
  logic [AW-1:0] line_addr;
  logic          sidx_in_line;
  logic [7:0]    up_q;
  logic          line_we;
  logic [7:0]    luma;

  assign sidx_ext     = 32'(sidx_r);
  assign line_addr    = sidx_ext[AW-1:0];
  assign sidx_in_line = sidx_ext < 32'(LINE_DEPTH);

  rsb_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (luma),
    .re    (accept),
    .raddr (line_addr),
    .rdata (up_q)
  );

  // Region clipping.
  logic [15:0] eff_w, eff_h;
  logic signed [17:0] sx, sy, sw, sh, xw, yh, cl, ct, cr, cb, dim_w, dim_h;
  logic [17:0] dx, dy, scx, scy;

  assign eff_w = rsb_pkg::eff_dim(img_w_r);
  assign eff_h = rsb_pkg::eff_dim(img_h_r);

  always_comb begin
    sx    = {{2{rx_r[15]}}, rx_r};
    sy    = {{2{ry_r[15]}}, ry_r};
    sw    = {{2{rw_r[15]}}, rw_r};
    sh    = {{2{rh_r[15]}}, rh_r};
    dim_w = {2'b00, eff_w};
    dim_h = {2'b00, eff_h};
    xw    = sx + sw;
    yh    = sy + sh;
    cl    = (sx < 18'sd0) ? 18'sd0 : sx;
    ct    = (sy < 18'sd0) ? 18'sd0 : sy;
    cr    = (xw < dim_w) ? xw : dim_w;
    cb    = (yh < dim_h) ? yh : dim_h;
    if (cr < cl) begin
      cr = cl;
    end
    if (cb < ct) begin
      cb = ct;
    end
    dx  = 18'(cr - cl);
    dy  = 18'(cb - ct);
    scx = dx >> rsb_pkg::GRID_SHIFT;
    scy = dy >> rsb_pkg::GRID_SHIFT;
  end

  // Pixel sampling.
  logic [15:0] wsum;
  logic        row_sampled, take, eol;
  logic [7:0]  g_left, g_up, up_val;
  logic [22:0] luma_upd;
  logic [23:0] grad_upd;
  logic [14:0] samp_upd;
  logic [15:0] pairs_upd;
  logic        size_bad, none_bad;

  always_comb begin
    wsum = 16'(16'd29 * c0_r) + 16'(16'd150 * c1_r) + 16'(16'd77 * c2_r) + 16'd128;
    luma = color_r ? wsum[15:8] : c0_r;
    row_sampled = (prow_r == nsr_r) && (nsr_r < bottom_r);
    take = busy_r && (op_r == rsb_pkg::OP_PIXEL) && row_sampled &&
           (pcol_r == nsc_r) && (nsc_r < right_r);
    eol = ({1'b0, pcol_r} + 16'd1) >= eff_w;
    up_val = sidx_in_line ? up_q : 8'd0;
    g_left = (sidx_r != '0) ? rsb_pkg::absdiff8(luma, lluma_r) : 8'd0;
    g_up   = !first_r ? rsb_pkg::absdiff8(luma, up_val) : 8'd0;
    luma_upd  = luma_tot_r;
    grad_upd  = grad_tot_r;
    samp_upd  = samp_tot_r;
    pairs_upd = pairs_r;
    if (take) begin
      luma_upd  = luma_tot_r + 23'(luma);
      grad_upd  = grad_tot_r + 24'(g_left) + 24'(g_up);
      samp_upd  = samp_tot_r + 15'd1;
      pairs_upd = pairs_r + 16'(sidx_r != '0) + 16'(!first_r);
    end
  end

  assign line_we = take & sidx_in_line;

  always_comb begin
    size_bad = ((right_r - left_r) < 15'd3) || ((bottom_r - top_r) < 15'd3);
    none_bad = (en_brt_r && samp_upd == '0) || (en_shp_r && pairs_upd == '0);
    job = '0;
    job.grad_sum = grad_upd;
    job.grad_cnt = pairs_upd;
    job.luma_sum = luma_upd;
    job.luma_cnt = samp_upd;
    if (!en_shp_r && !en_brt_r) begin
      job.ok = 1'b1;
    end else if (size_bad || none_bad) begin
      job.ok = 1'b0;
    end else begin
      job.ok     = 1'b1;
      job.do_shp = en_shp_r;
      job.do_brt = en_brt_r;
    end
  end

  assign job_push = busy_r && (op_r == rsb_pkg::OP_PIXEL) && last_r;

  always_comb begin
    left_nxt     = left_r;
    top_nxt      = top_r;
    right_nxt    = right_r;
    bottom_nxt   = bottom_r;
    step_col_nxt = step_col_r;
    step_row_nxt = step_row_r;
    pcol_nxt     = pcol_r;
    prow_nxt     = prow_r;
    nsc_nxt      = nsc_r;
    nsr_nxt      = nsr_r;
    sidx_nxt     = sidx_r;
    first_nxt    = first_r;
    lluma_nxt    = lluma_r;
    luma_tot_nxt = luma_tot_r;
    grad_tot_nxt = grad_tot_r;
    samp_tot_nxt = samp_tot_r;
    pairs_nxt    = pairs_r;
    if (busy_r && op_r == rsb_pkg::OP_REGION) begin
      left_nxt     = cl[14:0];
      top_nxt      = ct[14:0];
      right_nxt    = cr[14:0];
      bottom_nxt   = cb[14:0];
      step_col_nxt = (scx == '0) ? 9'd1 : scx[8:0];
      step_row_nxt = (scy == '0) ? 9'd1 : scy[8:0];
      pcol_nxt     = '0;
      prow_nxt     = '0;
      nsc_nxt      = cl[14:0];
      nsr_nxt      = ct[14:0];
      sidx_nxt     = '0;
      first_nxt    = 1'b1;
      lluma_nxt    = '0;
      luma_tot_nxt = '0;
      grad_tot_nxt = '0;
      samp_tot_nxt = '0;
      pairs_nxt    = '0;
    end else if (busy_r) begin
      luma_tot_nxt = luma_upd;
      grad_tot_nxt = grad_upd;
      samp_tot_nxt = samp_upd;
      pairs_nxt    = pairs_upd;
      if (take) begin
        lluma_nxt = luma;
        sidx_nxt  = sidx_r + 7'd1;
        nsc_nxt   = nsc_r + 15'(step_col_r);
      end
      if (eol) begin
        pcol_nxt = '0;
        prow_nxt = prow_r + 15'd1;
        if (row_sampled) begin
          nsr_nxt   = nsr_r + 15'(step_row_r);
          nsc_nxt   = left_r;
          sidx_nxt  = '0;
          first_nxt = 1'b0;
        end
      end else begin
        pcol_nxt = pcol_r + 15'd1;
      end
      // Restart the scan after the frame's result, keep the region.
      if (last_r) begin
        pcol_nxt     = '0;
        prow_nxt     = '0;
        nsc_nxt      = left_r;
        nsr_nxt      = top_r;
        sidx_nxt     = '0;
        first_nxt    = 1'b1;
        lluma_nxt    = '0;
        luma_tot_nxt = '0;
        grad_tot_nxt = '0;
        samp_tot_nxt = '0;
        pairs_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      top_r      <= '0;
      right_r    <= '0;
      bottom_r   <= '0;
      step_col_r <= 9'd1;
      step_row_r <= 9'd1;
      pcol_r     <= '0;
      prow_r     <= '0;
      nsc_r      <= '0;
      nsr_r      <= '0;
      sidx_r     <= '0;
      first_r    <= 1'b1;
      lluma_r    <= '0;
      luma_tot_r <= '0;
      grad_tot_r <= '0;
      samp_tot_r <= '0;
      pairs_r    <= '0;
    end else begin
      left_r     <= left_nxt;
      top_r      <= top_nxt;
      right_r    <= right_nxt;
      bottom_r   <= bottom_nxt;
      step_col_r <= step_col_nxt;
      step_row_r <= step_row_nxt;
      pcol_r     <= pcol_nxt;
      prow_r     <= prow_nxt;
      nsc_r      <= nsc_nxt;
      nsr_r      <= nsr_nxt;
      sidx_r     <= sidx_nxt;
      first_r    <= first_nxt;
      lluma_r    <= lluma_nxt;
      luma_tot_r <= luma_tot_nxt;
      grad_tot_r <= grad_tot_nxt;
      samp_tot_r <= samp_tot_nxt;
      pairs_r    <= pairs_nxt;
    end
  end

endmodule

FILE: sv/rsb_jobq.sv
// Two-entry queue of end-of-frame requests between front and back end.
module rsb_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsb_pkg::rsb_job_t job_in,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output rsb_pkg::rsb_job_t job_out
);

  rsb_pkg::rsb_job_t slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign job_out = slot_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr_r <= ~wptr_r;
      end
      if (pop && valid) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && valid);
    end
  end

endmodule

FILE: sv/rsb_back.sv
// Back end: serial division of the sums into Q1.16 scores and the result register.
module rsb_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  input  rsb_pkg::rsb_job_t            job,
  output logic                         job_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic                         out_ok,
  output logic [rsb_pkg::SCORE_W-1:0]  out_sharpness_score,
  output logic [rsb_pkg::SCORE_W-1:0]  out_brightness_score
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SHP  = 2'd1;
  localparam logic [1:0] S_BRT  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam int NW = rsb_pkg::DIV_N_W;
  localparam int DW = rsb_pkg::DIV_D_W;

  logic [1:0] state_r, state_nxt;
  rsb_pkg::rsb_job_t cur_r, cur_nxt;
  logic [NW-1:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [rsb_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rsb_pkg::SCORE_W-1:0] shp_r, shp_nxt;

  logic out_valid_r, out_valid_nxt;
  logic ok_r, ok_nxt;
  logic [rsb_pkg::SCORE_W-1:0] oshp_r, oshp_nxt, obrt_r, obrt_nxt;

  logic [DW:0]   trial;
  logic          qbit;
  logic [NW-1:0] quo_done;
  logic [rsb_pkg::SCORE_W-1:0] score;
  logic          div_last;

  assign out_empty            = ~out_valid_r;
  assign out_ok               = ok_r;
  assign out_sharpness_score  = oshp_r;
  assign out_brightness_score = obrt_r;
  assign job_pop              = (state_r == S_IDLE) && job_valid;

  // One restoring step per cycle.
  always_comb begin
    trial    = {rem_r, num_r[NW-1]};
    qbit     = trial >= {1'b0, den_r};
    quo_done = {quo_r[NW-2:0], qbit};
    score    = (quo_done > NW'(rsb_pkg::SCORE_ONE)) ? rsb_pkg::SCORE_ONE
                                                     : quo_done[rsb_pkg::SCORE_W-1:0];
    div_last = (cnt_r == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    shp_nxt       = shp_r;
    out_valid_nxt = out_valid_r;
    ok_nxt        = ok_r;
    oshp_nxt      = oshp_r;
    obrt_nxt      = obrt_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          cur_nxt = job;
          shp_nxt = '0;
          rem_nxt = '0;
          quo_nxt = '0;
          cnt_nxt = rsb_pkg::DIV_CNT_W'(NW - 1);
          if (job.do_shp) begin
            num_nxt   = {job.grad_sum, 16'd0};
            den_nxt   = {job.grad_cnt, 8'd0} - DW'(job.grad_cnt);
            state_nxt = S_SHP;
          end else if (job.do_brt) begin
            num_nxt   = {1'b0, job.luma_sum, 16'd0};
            den_nxt   = {1'b0, job.luma_cnt, 8'd0} - DW'(job.luma_cnt);
            state_nxt = S_BRT;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_SHP, S_BRT: begin
        num_nxt = num_r << 1;
        quo_nxt = quo_done;
        rem_nxt = qbit ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (div_last) begin
          if (state_r == S_SHP) begin
            shp_nxt = score;
            if (cur_r.do_brt) begin
              num_nxt   = {1'b0, cur_r.luma_sum, 16'd0};
              den_nxt   = {1'b0, cur_r.luma_cnt, 8'd0} - DW'(cur_r.luma_cnt);
              rem_nxt   = '0;
              quo_nxt   = '0;
              cnt_nxt   = rsb_pkg::DIV_CNT_W'(NW - 1);
              state_nxt = S_BRT;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            // Hold the brightness quotient until the result register is free.
            shp_nxt   = shp_r;
            quo_nxt   = quo_done;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          ok_nxt        = cur_r.ok;
          oshp_nxt      = cur_r.do_shp ? shp_r : '0;
          obrt_nxt      = cur_r.do_brt ? ((quo_r > NW'(rsb_pkg::SCORE_ONE)) ?
                            rsb_pkg::SCORE_ONE : quo_r[rsb_pkg::SCORE_W-1:0]) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
    shp_r  <= shp_nxt;
    ok_r   <= ok_nxt;
    oshp_r <= oshp_nxt;
    obrt_r <= obrt_nxt;
  end

endmodule

FILE: sv/roi_sharpness_brightness.sv
// Top level: focus and brightness measure over a clipped region of a raster frame.
//
// Input queue (in_push / in_full): a region-start request (in_op = 0) carries the
// rectangle; pixel requests (in_op = 1) follow in raster order. Every request
// passes through the front end in order: a read of the previous sampled row from
// the line store, then sampling and accumulation. No new request is taken until
// the previous one has been sampled.
// A pixel with in_last_pixel set queues one end-of-frame request (two-entry
// queue). The back end turns it into a result with a shared bit-serial divider,
// which computes each enabled score in turn.
// Result queue (out_empty / out_pop): one result register. While it is not
// popped the back end holds its next finished result and the front end keeps
// taking pixels until the request queue fills, then raises in_full.
// Configuration: cfg_valid / cfg_ready, always ready; write only while idle.
// Reset (rst_n low, synchronous) restores the register defaults, an empty region
// and an empty pipeline; the line store needs no clearing.
module roi_sharpness_brightness #(
  parameter int LINE_DEPTH = rsb_pkg::LINE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_op,
  input  logic signed [15:0]             in_rect_x,
  input  logic signed [15:0]             in_rect_y,
  input  logic signed [15:0]             in_rect_w,
  input  logic signed [15:0]             in_rect_h,
  input  logic [7:0]                     in_chan0,
  input  logic [7:0]                     in_chan1,
  input  logic [7:0]                     in_chan2,
  input  logic                           in_last_pixel,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic                           out_ok,
  output logic [rsb_pkg::SCORE_W-1:0]    out_sharpness_score,
  output logic [rsb_pkg::SCORE_W-1:0]    out_brightness_score
);

  logic              q_full, job_push, job_valid, job_pop;
  rsb_pkg::rsb_job_t job_in, job_out;

  assign cfg_ready = 1'b1;

  rsb_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_rect_x     (in_rect_x),
    .in_rect_y     (in_rect_y),
    .in_rect_w     (in_rect_w),
    .in_rect_h     (in_rect_h),
    .in_chan0      (in_chan0),
    .in_chan1      (in_chan1),
    .in_chan2      (in_chan2),
    .in_last_pixel (in_last_pixel),
    .q_full        (q_full),
    .job_push      (job_push),
    .job           (job_in)
  );

  rsb_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .job_in  (job_in),
    .full    (q_full),
    .pop     (job_pop),
    .valid   (job_valid),
    .job_out (job_out)
  );

  rsb_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .job_valid            (job_valid),
    .job                  (job_out),
    .job_pop              (job_pop),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_ok               (out_ok),
    .out_sharpness_score  (out_sharpness_score),
    .out_brightness_score (out_brightness_score)
  );

endmodule

FILE: verif/roi_sharpness_brightness_tb.sv
// Self-checking testbench for the region sharpness and brightness measure block.
module roi_sharpness_brightness_tb;

  typedef struct {
    logic              op;
    logic signed [15:0] rx, ry, rw, rh;
    logic [7:0]        c0, c1, c2;
    logic              last;
  } frame_item_t;

  typedef struct {
    logic              ok;
    logic [rsb_pkg::SCORE_W-1:0] shp;
    logic [rsb_pkg::SCORE_W-1:0] brt;
  } score_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [rsb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rsb_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_push, in_full, in_op, in_last_pixel;
  logic signed [15:0] in_rect_x, in_rect_y, in_rect_w, in_rect_h;
  logic [7:0] in_chan0, in_chan1, in_chan2;
  logic out_empty, out_pop, out_ok;
  logic [rsb_pkg::SCORE_W-1:0] out_sharpness_score, out_brightness_score;

  frame_item_t pending_items[$];
  score_t expected_scores[$];
  int errors = 0;
  int items_queued = 0;
  int in_gap = 0, out_gap = 0;
  bit no_idle = 0;

  // predictor state
  int unsigned img_w, img_h, gray_n_color, en_shp, en_brt;
  int unsigned reg_l, reg_t, reg_r, reg_b, step_c, step_r;
  int unsigned pos_col, pos_row, samp_col, samp_row, samp_idx, top_row, left_luma;
  int unsigned line_luma[rsb_pkg::LINE_DEPTH];
  int unsigned luma_sum, grad_sum, luma_cnt, grad_cnt;

  roi_sharpness_brightness dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > rsb_pkg::MAX_DIM) return rsb_pkg::MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned abs_diff(int unsigned a, int unsigned b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int unsigned q16_ratio(int unsigned sum, int unsigned cnt);
    longint unsigned q;
    q = (longint'(sum) << 16) / (longint'(cnt) * 255);
    return q > 65536 ? 65536 : int'(q);
  endfunction

  function automatic void restart_scan();
    pos_col = 0; pos_row = 0;
    samp_col = reg_l; samp_row = reg_t;
    samp_idx = 0; top_row = 1; left_luma = 0;
    luma_sum = 0; grad_sum = 0; luma_cnt = 0; grad_cnt = 0;
  endfunction

  function automatic void reset_model();
    img_w = 640; img_h = 480; gray_n_color = 1; en_shp = 1; en_brt = 1;
    reg_l = 0; reg_t = 0; reg_r = 0; reg_b = 0; step_c = 1; step_r = 1;
    foreach (line_luma[i]) line_luma[i] = 0;
    restart_scan();
  endfunction

  function automatic void take_sample(int unsigned luma);
    int unsigned up;
    luma_sum = (luma_sum + luma) & 32'h7FFFFF;
    luma_cnt = (luma_cnt + 1) & 32'h7FFF;
    if (samp_idx != 0) begin
      grad_sum = (grad_sum + abs_diff(luma, left_luma)) & 32'hFFFFFF;
      grad_cnt = (grad_cnt + 1) & 32'hFFFF;
    end
    if (!top_row) begin
      up = samp_idx < rsb_pkg::LINE_DEPTH ? line_luma[samp_idx] : 0;
      grad_sum = (grad_sum + abs_diff(luma, up)) & 32'hFFFFFF;
      grad_cnt = (grad_cnt + 1) & 32'hFFFF;
    end
    if (samp_idx < rsb_pkg::LINE_DEPTH) line_luma[samp_idx] = luma;
    left_luma = luma;
    samp_idx = (samp_idx + 1) & 32'h7F;
    samp_col = (samp_col + step_c) & 32'h7FFF;
  endfunction

  // Advance the model by one accepted request; return 1 when it yields a result.
  function automatic bit predict_request(frame_item_t it, output score_t res);
    longint x, y, w, h, fw, fh, l, t, r, b, sc, sr;
    int unsigned luma, wd;
    bit row_hit;
    res = '{0, 0, 0};
    if (it.op == rsb_pkg::OP_REGION) begin
      x = it.rx; y = it.ry; w = it.rw; h = it.rh;
      fw = clamp_dim(img_w); fh = clamp_dim(img_h);
      l = x < 0 ? 0 : x;
      t = y < 0 ? 0 : y;
      r = x + w < fw ? x + w : fw;
      b = y + h < fh ? y + h : fh;
      if (r < l) r = l;
      if (b < t) b = t;
      sc = (r - l) / 64; sr = (b - t) / 64;
      if (sc < 1) sc = 1;
      if (sr < 1) sr = 1;
      reg_l = l & 32'h7FFF; reg_t = t & 32'h7FFF;
      reg_r = r & 32'h7FFF; reg_b = b & 32'h7FFF;
      step_c = sc & 32'h1FF; step_r = sr & 32'h1FF;
      restart_scan();
      return 0;
    end
    wd = clamp_dim(img_w);
    if (gray_n_color)
      luma = (29 * it.c0 + 150 * it.c1 + 77 * it.c2 + 128) >> 8;
    else
      luma = it.c0;
    row_hit = pos_row == samp_row && samp_row < reg_b;
    if (row_hit && pos_col == samp_col && samp_col < reg_r) take_sample(luma);
    if (pos_col + 1 >= wd) begin
      pos_col = 0;
      pos_row = (pos_row + 1) & 32'h7FFF;
      if (row_hit) begin
        samp_row = (samp_row + step_r) & 32'h7FFF;
        samp_col = reg_l;
        samp_idx = 0;
        top_row = 0;
      end
    end else begin
      pos_col = pos_col + 1;
    end
    if (!it.last) return 0;
    if (!en_shp && !en_brt) begin
      res.ok = 1;
    end else if (reg_r - reg_l < 3 || reg_b - reg_t < 3) begin
      res.ok = 0;
    end else if ((en_brt && luma_cnt == 0) || (en_shp && grad_cnt == 0)) begin
      res.ok = 0;
    end else begin
      res.ok = 1;
      if (en_shp) res.shp = rsb_pkg::SCORE_W'(q16_ratio(grad_sum, grad_cnt));
      if (en_brt) res.brt = rsb_pkg::SCORE_W'(q16_ratio(luma_sum, luma_cnt));
    end
    restart_scan();
    return 1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 0;
    end else if (!in_push || !in_full) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_push <= 0;
      end else if (pending_items.size() > 0) begin
        in_push <= 1;
        in_op <= pending_items[0].op;
        in_rect_x <= pending_items[0].rx;
        in_rect_y <= pending_items[0].ry;
        in_rect_w <= pending_items[0].rw;
        in_rect_h <= pending_items[0].rh;
        in_chan0 <= pending_items[0].c0;
        in_chan1 <= pending_items[0].c1;
        in_chan2 <= pending_items[0].c2;
        in_last_pixel <= pending_items[0].last;
        void'(pending_items.pop_front());
        in_gap <= pick_gap();
      end else begin
        in_push <= 0;
      end
    end
  end

  // accepted requests, config writes, and result checks
  always @(posedge clk) begin
    frame_item_t it;
    score_t res, exp_res;
    if (!rst_n) begin
      out_pop <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rsb_pkg::REG_IMAGE_WIDTH:  img_w = cfg_data;
          rsb_pkg::REG_IMAGE_HEIGHT: img_h = cfg_data;
          rsb_pkg::REG_COLOR_MODE:   gray_n_color = cfg_data[0];
          rsb_pkg::REG_EN_SHARP:     en_shp = cfg_data[0];
          rsb_pkg::REG_EN_BRIGHT:    en_brt = cfg_data[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        it = '{in_op, in_rect_x, in_rect_y, in_rect_w, in_rect_h,
               in_chan0, in_chan1, in_chan2, in_last_pixel};
        if (predict_request(it, res)) expected_scores.insert(expected_scores.size(), res);
      end
      if (out_pop && !out_empty) begin
        if (expected_scores.size() == 0) begin
          $error("result with no expectation pending");
          errors++;
        end else begin
          exp_res = expected_scores.pop_front();
          if (out_ok !== exp_res.ok) begin
            $error("ok: expected %0d actual %0d", exp_res.ok, out_ok);
            errors++;
          end
          if (out_sharpness_score !== exp_res.shp) begin
            $error("sharpness_score: expected %0d actual %0d", exp_res.shp,
                   out_sharpness_score);
            errors++;
          end
          if (out_brightness_score !== exp_res.brt) begin
            $error("brightness_score: expected %0d actual %0d", exp_res.brt,
                   out_brightness_score);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_pop <= 0;
      end else begin
        out_pop <= 1;
        out_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(logic [rsb_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= rsb_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_push || expected_scores.size() > 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, bit color, bit es, bit eb);
    write_reg(rsb_pkg::REG_IMAGE_WIDTH, w);
    write_reg(rsb_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(rsb_pkg::REG_COLOR_MODE, color);
    write_reg(rsb_pkg::REG_EN_SHARP, es);
    write_reg(rsb_pkg::REG_EN_BRIGHT, eb);
  endtask

  task automatic add_region(int x, int y, int w, int h);
    frame_item_t it;
    it = '{rsb_pkg::OP_REGION, 16'(x), 16'(y), 16'(w), 16'(h),
           8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)};
    pending_items.insert(pending_items.size(), it);
    items_queued++;
  endtask

  // pattern: 0 random, 1 extremes, 2 flat gray
  task automatic add_pixels(int n, int pattern);
    frame_item_t it;
    for (int i = 0; i < n; i++) begin
      it = '{rsb_pkg::OP_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), i == n - 1};
      if (pattern == 1) begin
        it.c0 = (i % 2) ? 8'hFF : 8'h00;
        it.c1 = (i % 3) ? 8'hFF : 8'h00;
        it.c2 = ((i / 2) % 2) ? 8'hFF : 8'h00;
      end else if (pattern == 2) begin
        it.c0 = 8'd128; it.c1 = 8'd128; it.c2 = 8'd128;
      end
      pending_items.insert(pending_items.size(), it);
      items_queued++;
    end
  endtask

  initial begin
    int fw, fh, n, p;
    rst_n = 0;
    cfg_valid = 0; cfg_index = rsb_pkg::REG_IMAGE_WIDTH; cfg_data = '0;
    in_push = 0; in_op = rsb_pkg::OP_PIXEL; in_last_pixel = 0;
    in_rect_x = 0; in_rect_y = 0; in_rect_w = 0; in_rect_h = 0;
    in_chan0 = 0; in_chan1 = 0; in_chan2 = 0;
    out_pop = 0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // pixels before any region, then a degenerate extreme rectangle
    add_pixels(2, 0);
    add_region(-32768, 32767, 32767, -32768);
    add_pixels(1, 0);
    wait_idle();

    configure(5, 4, 1, 1, 1);
    add_region(-2, -1, 20, 20);
    add_pixels(20, 1);
    add_region(1, 1, 2, 2);
    add_pixels(20, 0);
    wait_idle();

    configure(5, 4, 0, 0, 1);
    add_region(0, 0, 5, 4);
    add_pixels(20, 2);
    wait_idle();

    // oversized and zero dimensions, and a grid with a column step above one
    configure(32767, 0, 1, 1, 0);
    add_region(32767, -5, -32768, 100);
    add_pixels(3, 0);
    wait_idle();
    configure(130, 3, 1, 1, 1);
    add_region(0, 0, 130, 3);
    add_pixels(390, 0);
    wait_idle();

    while (items_queued < 1300) begin
      p = $urandom_range(99);
      if (p < 75) begin
        fw = $urandom_range(12, 1);
        fh = $urandom_range(10, 1);
      end else begin
        fw = (p < 85) ? 16384 : (p < 90) ? 0 : $urandom_range(32767);
        fh = (p % 2) ? 16384 : $urandom_range(32767);
      end
      no_idle = ($urandom_range(3) == 0);
      configure(fw, fh, 1'($urandom_range(1)), $urandom_range(3) != 0,
                $urandom_range(3) != 0);
      fw = clamp_dim(fw);
      fh = clamp_dim(fh);
      repeat ($urandom_range(4, 1)) begin
        p = $urandom_range(99);
        if (p < 80)
          add_region($urandom_range(fw + 2) - 3, $urandom_range(fh + 2) - 3,
                     $urandom_range(fw + 3), $urandom_range(fh + 3));
        else if (p < 90)
          add_region($signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $signed(16'($urandom)));
        if (fw * fh <= 150 && $urandom_range(99) < 85) n = fw * fh;
        else n = $urandom_range(40, 1);
        add_pixels(n, $urandom_range(9) == 0 ? 1 : 0);
      end
      wait_idle();
    end
    no_idle = 0;

    do @(posedge clk);
    while (expected_scores.size() > 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(20 * 1000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
